// ===== design/lrp_pkg.sv =====
// LR parser package: sizes, field widths, entry encoding limits, codes and shared types.
// No dependencies; every design file references it by scoped names.
package lrp_pkg;

  localparam int NUM_STATES  = 128;
  localparam int NUM_COLUMNS = 16;
  localparam int NUM_RULES   = 32;
  localparam int STACK_DEPTH = 128;
  localparam int MAX_REDUCES = 16;

  localparam int STATE_W   = $clog2(NUM_STATES);
  localparam int COL_W     = $clog2(NUM_COLUMNS);
  localparam int RULE_W    = $clog2(NUM_RULES);
  localparam int LEN_W     = 4;
  localparam int ENTRY_W   = 15;
  localparam int LEVEL_W   = 8;
  localparam int SP_W      = $clog2(STACK_DEPTH + 1);
  localparam int NUM_SLOTS = STACK_DEPTH / 2;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int RCNT_W    = $clog2(MAX_REDUCES + 1);
  localparam int TBL_AW    = STATE_W + COL_W;
  localparam int TBL_DEPTH = NUM_STATES * NUM_COLUMNS;
  localparam int CALC_W    = ((SP_W > LEN_W + 1) ? SP_W : LEN_W + 1) + 1;

  localparam logic signed [ENTRY_W-1:0] SHIFT_BASE  = ENTRY_W'(100);
  localparam logic signed [ENTRY_W-1:0] SHIFT_END   = ENTRY_W'(999);
  localparam logic signed [ENTRY_W-1:0] REDUCE_BASE = ENTRY_W'(1000);
  localparam logic signed [ENTRY_W-1:0] REDUCE_END  = ENTRY_W'(9999);
  localparam logic signed [ENTRY_W-1:0] ACCEPT_CODE = ENTRY_W'(10000);
  localparam logic [ENTRY_W-1:0] STATE_LIMIT = ENTRY_W'(NUM_STATES);
  localparam logic [ENTRY_W-1:0] RULE_LIMIT  = ENTRY_W'(NUM_RULES);

  typedef enum logic [1:0] {
    OP_WRITE_ENTRY = 2'd0,
    OP_WRITE_RULE  = 2'd1,
    OP_PARSE       = 2'd2,
    OP_RESTART     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_SHIFT  = 3'd0,
    ACT_REDUCE = 3'd1,
    ACT_ACCEPT = 3'd2,
    ACT_REJECT = 3'd3,
    ACT_ERROR  = 3'd4,
    ACT_DONE   = 3'd5
  } act_t;

  typedef enum logic [2:0] {
    K_REJECT = 3'd0,
    K_SHIFT  = 3'd1,
    K_REDUCE = 3'd2,
    K_ACCEPT = 3'd3,
    K_BAD    = 3'd4,
    K_GOTO   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               ok;
    logic [STATE_W-1:0] idx;
  } dec_t;

  typedef struct packed {
    logic               we;
    logic [TBL_AW-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } tbl_req_t;

  typedef struct packed {
    logic              we;
    logic [RULE_W-1:0] idx;
    logic [COL_W-1:0]  lhs;
    logic [LEN_W-1:0]  len;
  } rule_wr_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  slot;
    logic [STATE_W-1:0] state;
  } stk_wr_t;

endpackage

// ===== design/lrp_decode.sv =====
// LR parser entry decoder: the shared subtract and compare unit for action and goto entries.
// Depends on lrp_pkg.
module lrp_decode (
  input  logic signed [lrp_pkg::ENTRY_W-1:0] entry,
  input  logic                               goto_mode,
  output lrp_pkg::dec_t                      dec
);

  logic signed [lrp_pkg::ENTRY_W-1:0] base;
  logic signed [lrp_pkg::ENTRY_W-1:0] diff;
  logic                               fits_state;
  logic                               fits_rule;

  always_comb begin
    priority if (goto_mode) begin
      base = '0;
    end else if (entry >= lrp_pkg::REDUCE_BASE) begin
      base = lrp_pkg::REDUCE_BASE;
    end else begin
      base = lrp_pkg::SHIFT_BASE;
    end
  end

  assign diff       = entry - base;
  assign fits_state = !diff[lrp_pkg::ENTRY_W-1] && ($unsigned(diff) < lrp_pkg::STATE_LIMIT);
  assign fits_rule  = !diff[lrp_pkg::ENTRY_W-1] && ($unsigned(diff) < lrp_pkg::RULE_LIMIT);

  always_comb begin
    dec.idx = diff[lrp_pkg::STATE_W-1:0];
    dec.ok  = 1'b0;
    priority if (goto_mode) begin
      dec.kind = lrp_pkg::K_GOTO;
      dec.ok   = fits_state;
    end else if (entry < 0) begin
      dec.kind = lrp_pkg::K_BAD;
    end else if (entry == 0) begin
      dec.kind = lrp_pkg::K_REJECT;
    end else if (entry < lrp_pkg::SHIFT_BASE) begin
      dec.kind = lrp_pkg::K_BAD;
    end else if (entry <= lrp_pkg::SHIFT_END) begin
      dec.kind = lrp_pkg::K_SHIFT;
      dec.ok   = fits_state;
    end else if (entry <= lrp_pkg::REDUCE_END) begin
      dec.kind = lrp_pkg::K_REDUCE;
      dec.ok   = fits_rule;
    end else if (entry == lrp_pkg::ACCEPT_CODE) begin
      dec.kind = lrp_pkg::K_ACCEPT;
    end else begin
      dec.kind = lrp_pkg::K_BAD;
    end
  end

endmodule

// ===== design/lrp_tables.sv =====
// LR parser tables: action/goto memory with registered read, and the rule table.
// Depends on lrp_pkg.
module lrp_tables (
  input  logic                              clk,
  input  lrp_pkg::tbl_req_t                 tbl_req,
  output logic signed [lrp_pkg::ENTRY_W-1:0] tbl_rdata,
  input  lrp_pkg::rule_wr_t                 rule_wr,
  input  logic [lrp_pkg::RULE_W-1:0]        rule_ridx,
  output logic [lrp_pkg::COL_W-1:0]         rule_lhs,
  output logic [lrp_pkg::LEN_W-1:0]         rule_len
);

  logic [lrp_pkg::ENTRY_W-1:0] act_mem [lrp_pkg::TBL_DEPTH];
  logic [lrp_pkg::ENTRY_W-1:0] rdata_r;
  logic [lrp_pkg::COL_W-1:0]   lhs_r [lrp_pkg::NUM_RULES];
  logic [lrp_pkg::LEN_W-1:0]   len_r [lrp_pkg::NUM_RULES];

  always_ff @(posedge clk) begin
    if (tbl_req.we) begin
      act_mem[tbl_req.addr] <= tbl_req.wdata;
    end
    rdata_r <= act_mem[tbl_req.addr];
  end

  always_ff @(posedge clk) begin
    if (rule_wr.we) begin
      lhs_r[rule_wr.idx] <= rule_wr.lhs;
      len_r[rule_wr.idx] <= rule_wr.len;
    end
  end

  assign tbl_rdata = $signed(rdata_r);
  assign rule_lhs  = lhs_r[rule_ridx];
  assign rule_len  = len_r[rule_ridx];

endmodule

// ===== design/lrp_stack.sv =====
// LR parser state stack: one slot per pushed state, registered read, bottom slot reads zero.
// Depends on lrp_pkg.
module lrp_stack (
  input  logic                        clk,
  input  lrp_pkg::stk_wr_t            wr,
  input  logic [lrp_pkg::SLOT_W-1:0]  rd_slot,
  output logic [lrp_pkg::STATE_W-1:0] rd_state
);

  logic [lrp_pkg::STATE_W-1:0] mem [lrp_pkg::NUM_SLOTS];
  logic [lrp_pkg::STATE_W-1:0] rdata_r;
  logic                        bottom_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.slot] <= wr.state;
    end
    rdata_r  <= mem[rd_slot];
    bottom_r <= (rd_slot == '0);
  end

  assign rd_state = bottom_r ? '0 : rdata_r;

endmodule

// ===== design/lr_shift_reduce_parser_top.sv =====
// LR shift-reduce parser top: input/result channels, parse sequencer and result register.
// Depends on lrp_pkg, lrp_decode, lrp_tables and lrp_stack.
//
// Input channel (in_*): one transfer per item. Operation selects a table entry write,
// a rule write, a token parse or a restart. in_stall is high while an item is in work.
// Result channel (out_*): one transfer per action; out_last marks the final result
// of an item. A single output register holds the result until it is taken.
// A table or rule write or a restart goes from idle straight to the emit state. A token
// is decoded and ends in a shift, accept, reject or error; each reduce before it goes
// through the goto read, goto decode, emit and a new lookup, as the one-port action
// table read, the registered stack read and the shared entry decoder serve each reduce in turn.
// A token after an accept answers error straight from idle.
// Reset (rst_n low, synchronous) empties the stack to state 0, clears the accept
// flag and drops any held result; the tables keep their contents, and the user must
// have written them before they are read; the block does not enforce this. When
// out_stall is high the sequencer holds its next result and waits; no item is taken
// until the final result of the current one sits in the output register.
module lr_shift_reduce_parser_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_operation,
  input  logic [lrp_pkg::STATE_W-1:0]        in_row,
  input  logic [lrp_pkg::COL_W-1:0]          in_column,
  input  logic signed [lrp_pkg::ENTRY_W-1:0] in_entry,
  input  logic [lrp_pkg::RULE_W-1:0]         in_rule_index,
  input  logic [lrp_pkg::COL_W-1:0]          in_rule_lhs,
  input  logic [lrp_pkg::LEN_W-1:0]          in_rule_length,
  input  logic [lrp_pkg::COL_W-1:0]          in_token_class,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         out_action,
  output logic [lrp_pkg::STATE_W-1:0]        out_value,
  output logic [lrp_pkg::STATE_W-1:0]        out_goto_state,
  output logic [lrp_pkg::LEVEL_W-1:0]        out_stack_level,
  output logic                               out_last
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_DEC   = 6'b000100,
    S_GREAD = 6'b001000,
    S_GDEC  = 6'b010000,
    S_EMIT  = 6'b100000
  } seq_state_t;

  typedef struct packed {
    lrp_pkg::act_t               act;
    logic [lrp_pkg::STATE_W-1:0] value;
    logic [lrp_pkg::STATE_W-1:0] goto_state;
    logic [lrp_pkg::LEVEL_W-1:0] level;
    logic                        last;
  } res_t;

  seq_state_t                   st_r, st_nxt;
  logic [lrp_pkg::SP_W-1:0]     sp_r, sp_nxt;
  logic [lrp_pkg::STATE_W-1:0]  top_r, top_nxt;
  logic                         accepted_r, accepted_nxt;
  logic [lrp_pkg::RCNT_W-1:0]   rcnt_r, rcnt_nxt;
  logic [lrp_pkg::COL_W-1:0]    tok_r, tok_nxt;
  logic [lrp_pkg::COL_W-1:0]    lhs_r, lhs_nxt;
  logic [lrp_pkg::RULE_W-1:0]   rule_r, rule_nxt;
  logic [lrp_pkg::SP_W-1:0]     base_r, base_nxt;
  res_t                         res_r, res_nxt;
  res_t                         out_r;
  logic                         out_valid_r;

  lrp_pkg::tbl_req_t                  tbl_req;
  logic signed [lrp_pkg::ENTRY_W-1:0] tbl_rdata;
  lrp_pkg::rule_wr_t                  rule_wr;
  logic [lrp_pkg::RULE_W-1:0]         rule_ridx;
  logic [lrp_pkg::COL_W-1:0]          rule_lhs;
  logic [lrp_pkg::LEN_W-1:0]          rule_len;
  lrp_pkg::stk_wr_t                   stk_wr;
  logic [lrp_pkg::SLOT_W-1:0]         stk_rd_slot;
  logic [lrp_pkg::STATE_W-1:0]        stk_rd_state;
  lrp_pkg::dec_t                      dec;

  logic                         in_xfer;
  logic                         out_free;
  logic [lrp_pkg::CALC_W-1:0]   sp_c;
  logic [lrp_pkg::CALC_W-1:0]   sp_p2;
  logic [lrp_pkg::CALC_W-1:0]   pops_c;
  logic [lrp_pkg::CALC_W-1:0]   rbase_c;
  logic [lrp_pkg::CALC_W-1:0]   rbase_p2;
  logic [lrp_pkg::CALC_W-1:0]   base_p2;
  res_t                         err_res;

  lrp_decode u_decode (
    .entry     (tbl_rdata),
    .goto_mode (st_r == S_GDEC),
    .dec       (dec)
  );

  lrp_tables u_tables (
    .clk       (clk),
    .tbl_req   (tbl_req),
    .tbl_rdata (tbl_rdata),
    .rule_wr   (rule_wr),
    .rule_ridx (rule_ridx),
    .rule_lhs  (rule_lhs),
    .rule_len  (rule_len)
  );

  lrp_stack u_stack (
    .clk      (clk),
    .wr       (stk_wr),
    .rd_slot  (stk_rd_slot),
    .rd_state (stk_rd_state)
  );

  assign in_stall = (st_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign sp_c     = lrp_pkg::CALC_W'(sp_r);
  assign sp_p2    = sp_c + lrp_pkg::CALC_W'(2);
  assign pops_c   = lrp_pkg::CALC_W'({rule_len, 1'b0});
  assign rbase_c  = sp_c - pops_c;
  assign rbase_p2 = rbase_c + lrp_pkg::CALC_W'(2);
  assign base_p2  = lrp_pkg::CALC_W'(base_r) + lrp_pkg::CALC_W'(2);
  assign rule_ridx = dec.idx[lrp_pkg::RULE_W-1:0];

  always_comb begin
    err_res.act        = lrp_pkg::ACT_ERROR;
    err_res.value      = '0;
    err_res.goto_state = top_r;
    err_res.level      = lrp_pkg::LEVEL_W'(sp_r);
    err_res.last       = 1'b1;
  end

  always_comb begin
    st_nxt       = st_r;
    sp_nxt       = sp_r;
    top_nxt      = top_r;
    accepted_nxt = accepted_r;
    rcnt_nxt     = rcnt_r;
    tok_nxt      = tok_r;
    lhs_nxt      = lhs_r;
    rule_nxt     = rule_r;
    base_nxt     = base_r;
    res_nxt      = res_r;
    tbl_req      = '0;
    rule_wr      = '0;
    stk_wr       = '0;
    stk_rd_slot  = '0;
    unique case (st_r)
      S_IDLE: begin
        tbl_req.addr = {top_r, in_token_class};
        if (in_xfer) begin
          res_nxt            = err_res;
          res_nxt.act        = lrp_pkg::ACT_DONE;
          st_nxt             = S_EMIT;
          unique case (lrp_pkg::op_t'(in_operation))
            lrp_pkg::OP_WRITE_ENTRY: begin
              tbl_req.we    = 1'b1;
              tbl_req.addr  = {in_row, in_column};
              tbl_req.wdata = in_entry;
            end
            lrp_pkg::OP_WRITE_RULE: begin
              rule_wr.we  = 1'b1;
              rule_wr.idx = in_rule_index;
              rule_wr.lhs = in_rule_lhs;
              rule_wr.len = in_rule_length;
            end
            lrp_pkg::OP_PARSE: begin
              rcnt_nxt = '0;
              tok_nxt  = in_token_class;
              if (accepted_r) begin
                res_nxt = err_res;
              end else begin
                st_nxt = S_DEC;
              end
            end
            lrp_pkg::OP_RESTART: begin
              sp_nxt             = lrp_pkg::SP_W'(1);
              top_nxt            = '0;
              accepted_nxt       = 1'b0;
              res_nxt.goto_state = '0;
              res_nxt.level      = lrp_pkg::LEVEL_W'(1);
            end
            default: begin
              res_nxt = err_res;
            end
          endcase
        end
      end
      S_LOOK: begin
        tbl_req.addr = {top_r, tok_r};
        st_nxt       = S_DEC;
      end
      S_DEC: begin
        res_nxt = err_res;
        st_nxt  = S_EMIT;
        unique case (dec.kind)
          lrp_pkg::K_REJECT: begin
            res_nxt.act = lrp_pkg::ACT_REJECT;
          end
          lrp_pkg::K_ACCEPT: begin
            accepted_nxt = 1'b1;
            res_nxt.act  = lrp_pkg::ACT_ACCEPT;
          end
          lrp_pkg::K_SHIFT: begin
            if (dec.ok && (sp_p2 <= lrp_pkg::CALC_W'(lrp_pkg::STACK_DEPTH))) begin
              stk_wr.we          = 1'b1;
              stk_wr.slot        = sp_p2[lrp_pkg::SLOT_W:1];
              stk_wr.state       = dec.idx;
              sp_nxt             = sp_p2[lrp_pkg::SP_W-1:0];
              top_nxt            = dec.idx;
              res_nxt.act        = lrp_pkg::ACT_SHIFT;
              res_nxt.value      = dec.idx;
              res_nxt.goto_state = dec.idx;
              res_nxt.level      = lrp_pkg::LEVEL_W'(sp_p2);
            end
          end
          lrp_pkg::K_REDUCE: begin
            if ((rcnt_r < lrp_pkg::RCNT_W'(lrp_pkg::MAX_REDUCES)) && dec.ok &&
                (pops_c <= sp_c - lrp_pkg::CALC_W'(1)) &&
                (rbase_p2 <= lrp_pkg::CALC_W'(lrp_pkg::STACK_DEPTH))) begin
              stk_rd_slot = rbase_c[lrp_pkg::SLOT_W:1];
              rule_nxt    = rule_ridx;
              lhs_nxt     = rule_lhs;
              base_nxt    = rbase_c[lrp_pkg::SP_W-1:0];
              st_nxt      = S_GREAD;
            end
          end
          default: begin
            res_nxt = err_res;
          end
        endcase
      end
      S_GREAD: begin
        tbl_req.addr = {stk_rd_state, lhs_r};
        st_nxt       = S_GDEC;
      end
      S_GDEC: begin
        res_nxt = err_res;
        st_nxt  = S_EMIT;
        if (dec.ok) begin
          stk_wr.we          = 1'b1;
          stk_wr.slot        = base_p2[lrp_pkg::SLOT_W:1];
          stk_wr.state       = dec.idx;
          sp_nxt             = base_p2[lrp_pkg::SP_W-1:0];
          top_nxt            = dec.idx;
          rcnt_nxt           = rcnt_r + lrp_pkg::RCNT_W'(1);
          res_nxt.act        = lrp_pkg::ACT_REDUCE;
          res_nxt.value      = lrp_pkg::STATE_W'(rule_r);
          res_nxt.goto_state = dec.idx;
          res_nxt.level      = lrp_pkg::LEVEL_W'(base_p2);
          res_nxt.last       = 1'b0;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          st_nxt = res_r.last ? S_IDLE : S_LOOK;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      sp_r        <= lrp_pkg::SP_W'(1);
      top_r       <= '0;
      accepted_r  <= 1'b0;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      sp_r       <= sp_nxt;
      top_r      <= top_nxt;
      accepted_r <= accepted_nxt;
      rcnt_r     <= rcnt_nxt;
      if (st_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    lhs_r  <= lhs_nxt;
    rule_r <= rule_nxt;
    base_r <= base_nxt;
    res_r  <= res_nxt;
    if (st_r == S_EMIT && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_r.act;
  assign out_value       = out_r.value;
  assign out_goto_state  = out_r.goto_state;
  assign out_stack_level = out_r.level;
  assign out_last        = out_r.last;

  a_sp_odd: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r[0] && (sp_r < lrp_pkg::SP_W'(lrp_pkg::STACK_DEPTH)))
    else $error("stack pointer left the odd, in-range set");

  a_rcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= lrp_pkg::RCNT_W'(lrp_pkg::MAX_REDUCES))
    else $error("reduce count beyond limit");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT && out_free && res_r.last) |=> (st_r == S_IDLE && out_valid_r && out_last))
    else $error("final result did not return the sequencer to idle");

  a_reduce_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT && out_free && !res_r.last) |=>
      (st_r == S_LOOK && out_action == lrp_pkg::ACT_REDUCE))
    else $error("non-final result was not a reduce followed by a lookup");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("held result changed under stall");

endmodule
